FILE: rtl/tcma_pkg.sv
// Shared constants and operation codes for the two-channel moving average block.
package tcma_pkg;

    localparam int CFG_W = 7;
    localparam int OP_W  = 2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_AVG  = 2'd2
    } t_op;

endpackage

FILE: rtl/tcma_req_if.sv
// Request channel: operation, channel select and sample with valid/ready.
interface tcma_req_if
    import tcma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [OP_W-1:0]                operation;
    logic                           channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output operation, output channel, output sample,
                    input ready);
    modport sink   (input valid, input operation, input channel, input sample,
                    output ready);
endinterface

FILE: rtl/tcma_rsp_if.sv
// Response channel: popped sample or average with an empty flag, valid/ready.
interface tcma_rsp_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           was_empty;

    modport source (output valid, output value, output was_empty, input ready);
    modport sink   (input valid, input value, input was_empty, output ready);
endinterface

FILE: rtl/two_channel_moving_average_top.sv
// Two-channel ring buffer with push, pop and average operations over a shared store.
// A push completes without leaving the idle state; a pop reads the store and then returns
// the sample; an average reads n stored samples over the single read port of the store and
// then runs the one-bit-per-cycle divider. Requests are not taken while an operation is
// in progress. After reset the block clears both stores, one entry per cycle, before it
// takes the first request. A result waiting at the output does not stop a following push.
module two_channel_moving_average_top
    import tcma_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    tcma_req_if.sink         i_req,
    tcma_rsp_if.source       o_rsp
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = $clog2(2 * DEPTH);
    localparam int SW = SAMPLE_WIDTH + CW;
    localparam int S  = SAMPLE_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_POP, S_AVG, S_AVG_LAST, S_DIV_START, S_DIV, S_RESULT
    } t_state;

    function automatic logic [MW-1:0] f_addr(input logic ch, input logic [PW-1:0] pos);
        f_addr = ch ? MW'(pos) + MW'(DEPTH) : MW'(pos);
    endfunction

    t_state             r_state, n_state;
    logic [MW-1:0]      r_clr, n_clr;
    logic [CFG_W-1:0]   r_window, n_window;
    logic [PW-1:0]      r_pos [2];
    logic [PW-1:0]      n_pos [2];
    logic [CW-1:0]      r_cnt [2];
    logic [CW-1:0]      n_cnt [2];
    logic               r_ch, n_ch;
    logic [CW-1:0]      r_n, n_n;
    logic [PW-1:0]      r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic signed [SW-1:0] r_sum, n_sum;
    logic               r_neg, n_neg;
    logic [S-1:0]       r_value, n_value;
    logic               r_empty, n_empty;
    logic               r_out_valid, n_out_valid;
    logic [S-1:0]       r_out_value, n_out_value;
    logic               r_out_empty, n_out_empty;

    logic [CW-1:0]      w_eff;
    logic               accept;
    logic               ch_in;
    logic [PW-1:0]      pos_in;
    logic [CW-1:0]      cnt_in;
    logic [PW-1:0]      pos_push;
    logic               mem_we;
    logic [MW-1:0]      mem_waddr;
    logic [S-1:0]       mem_wdata;
    logic [MW-1:0]      mem_raddr;
    logic [S-1:0]       mem_rdata;
    logic signed [SW-1:0] rd_sext;
    logic               div_start;
    logic [SW-1:0]      div_dvd;
    logic               div_done;
    logic [SW-1:0]      div_quo;
    logic [S-1:0]       quo;

    always_comb begin
        if (r_window == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_window) > 32'(DEPTH)) begin
            w_eff = CW'(DEPTH);
        end else begin
            w_eff = CW'(r_window);
        end
    end

    assign accept   = i_req.valid && i_req.ready;
    assign ch_in    = i_req.channel;
    assign pos_in   = r_pos[ch_in];
    assign cnt_in   = r_cnt[ch_in];
    assign pos_push = (CW'(pos_in) >= w_eff - CW'(1)) ? '0 : pos_in + PW'(1);
    assign rd_sext  = {{CW{mem_rdata[S-1]}}, mem_rdata};
    assign div_dvd  = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign quo      = div_quo[S-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_window    = i_cfg_we ? i_cfg_data : r_window;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_n         = r_n;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_sum       = r_sum;
        n_neg       = r_neg;
        n_value     = r_value;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        n_out_empty = r_out_empty;
        mem_we      = 1'b0;
        mem_waddr   = f_addr(ch_in, pos_push);
        mem_wdata   = i_req.sample;
        mem_raddr   = f_addr(ch_in, pos_in);
        div_start   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + MW'(1);
                if (r_clr == MW'(2 * DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        OP_PUSH: begin
                            mem_we = 1'b1;
                            n_pos[ch_in] = pos_push;
                            if (cnt_in < w_eff) begin
                                n_cnt[ch_in] = cnt_in + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (cnt_in == '0) begin
                                n_value = '0;
                                n_empty = 1'b1;
                                n_state = S_RESULT;
                            end else begin
                                n_pos[ch_in] = (pos_in == '0) ? PW'(w_eff - CW'(1))
                                                              : pos_in - PW'(1);
                                n_state = S_POP;
                            end
                        end
                        OP_AVG: begin
                            if (cnt_in == '0) begin
                                n_value = '0;
                                n_empty = 1'b1;
                                n_state = S_RESULT;
                            end else begin
                                n_ch     = ch_in;
                                n_n      = cnt_in;
                                n_idx    = '0;
                                n_rd_vld = 1'b0;
                                n_sum    = '0;
                                n_state  = S_AVG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_value = mem_rdata;
                n_empty = 1'b0;
                n_state = S_RESULT;
            end
            S_AVG: begin
                mem_raddr = f_addr(r_ch, r_idx);
                n_rd_vld  = 1'b1;
                n_idx     = r_idx + PW'(1);
                if (r_rd_vld) begin
                    n_sum = r_sum + rd_sext;
                end
                if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_state = S_AVG_LAST;
                end
            end
            S_AVG_LAST: begin
                n_sum   = r_sum + rd_sext;
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_neg     = r_sum[SW-1];
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_value = r_neg ? -quo : quo;
                    n_empty = 1'b0;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_value;
                    n_out_empty = r_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_window    <= WINDOW_RESET;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_window    <= n_window;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_ch        <= n_ch;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_sum       <= n_sum;
        r_neg       <= n_neg;
        r_value     <= n_value;
        r_empty     <= n_empty;
        r_out_value <= n_out_value;
        r_out_empty <= n_out_empty;
    end

    tcma_mem #(
        .ENTRIES (2 * DEPTH),
        .WIDTH   (S)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcma_div #(
        .DVD_W (SW),
        .DVS_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.value     = r_out_value;
    assign o_rsp.was_empty = r_out_empty;
endmodule

FILE: rtl/tcma_mem.sv
// Sample store with one write port and one registered read port.
module tcma_mem #(
    parameter int ENTRIES = 128,
    parameter int WIDTH   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/tcma_div.sv
// Restoring divider that, once started, produces one quotient bit per cycle until done.
module tcma_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int KW = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [KW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
                r_dvd <= {r_dvd[DVD_W-2:0], ge};
                r_cnt <= r_cnt + KW'(1);
                if (r_cnt == KW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule
